/* hdl/ssg_pkg.sv */
`default_nettype none
package ssg_pkg;

  localparam int unsigned DEF_MAX_DIMS  = 4;
  localparam int unsigned DEF_MAX_ELEMS = 4096;

  localparam int unsigned IDX_W  = 12;  // elem_index width
  localparam int unsigned VAL_W  = 32;  // element width
  localparam int unsigned CFG_W  = 64;  // widest register
  localparam int unsigned CFG_AW = 3;   // register index width
  localparam int unsigned FLD_W  = 16;  // one packed per-dimension field
  localparam int unsigned NFLD   = 4;   // fields in a packed register
  localparam int unsigned X_W    = 34;  // signed multiplier operand
  localparam int unsigned DCNT_W = 4;   // dimension counter width

  typedef enum logic [CFG_AW-1:0] {
    REG_DIMS_USED  = 3'd0,
    REG_SLICE_DIMS = 3'd1,
    REG_IN_SHAPE   = 3'd2,
    REG_OUT_SHAPE  = 3'd3,
    REG_OFFSET     = 3'd4,
    REG_STEP       = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_STR_IN,
    ST_STR_OUT,
    ST_DIM,
    ST_DIV,
    ST_TERM,
    ST_MAC,
    ST_NEXT,
    ST_READ,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MS_IN_STR,
    MS_OUT_STR,
    MS_BASE
  } mac_src_t;

  typedef struct packed {
    logic              capture;
    logic              load_wr;
    logic              str_init;
    logic              mac_clr;
    logic              mac_en;
    mac_src_t          mac_src;
    logic [1:0]        chunk;
    logic              str_wr_in;
    logic              str_wr_out;
    logic              div_init;
    logic              div_step;
    logic              div_done;
    logic              div_zero;
    logic              term_en;
    logic [DCNT_W-1:0] dim;
    logic              rd_en;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [DCNT_W-1:0] dim_last;
    logic [DCNT_W-1:0] slice_n;
    logic              str_zero;
    logic              in_range;
    logic              out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hdl/ssg_if.sv */
`default_nettype none
interface ssg_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [ssg_pkg::IDX_W-1:0]      elem_index;
  logic signed [ssg_pkg::VAL_W-1:0] elem_value;

  modport source (output valid, req_type, elem_index, elem_value, input ready);
  modport sink (input valid, req_type, elem_index, elem_value, output ready);
endinterface

interface ssg_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [ssg_pkg::VAL_W-1:0] out_value;
  logic                           out_of_range;

  modport source (output valid, out_value, out_of_range, input ready);
  modport sink (input valid, out_value, out_of_range, output ready);
endinterface
`default_nettype wire

/* hdl/ssg_ram.sv */
`default_nettype none
module ssg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* hdl/ssg_ctrl.sv */
`default_nettype none
module ssg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_ready,
  output ssg_pkg::dp_cmd_t  cmd,
  input  ssg_pkg::dp_stat_t stat
);
  import ssg_pkg::*;

  localparam logic [3:0] DIV_LAST = 4'(IDX_W - 1);

  state_t            state_r, state_nxt;
  logic [DCNT_W-1:0] k_r, k_nxt;
  logic [1:0]        c_r, c_nxt;
  logic [3:0]        bc_r, bc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      c_r     <= '0;
      bc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      c_r     <= c_nxt;
      bc_r    <= bc_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    c_nxt     = c_r;
    bc_nxt    = bc_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.dim   = k_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_INIT;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_INIT: begin
        // innermost strides are one; walk outward from there
        cmd.dim      = stat.dim_last;
        cmd.str_init = 1'b1;
        cmd.mac_clr  = 1'b1;
        k_nxt        = stat.dim_last;
        c_nxt        = '0;
        if (stat.dim_last == '0) begin
          state_nxt = ST_DIM;
        end else begin
          state_nxt = ST_STR_IN;
        end
      end
      ST_STR_IN: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_src = MS_IN_STR;
        cmd.chunk   = c_r;
        c_nxt       = c_r + 2'd1;
        if (c_r == 2'd3) begin
          cmd.str_wr_in = 1'b1;
          cmd.mac_clr   = 1'b1;
          state_nxt     = ST_STR_OUT;
        end
      end
      ST_STR_OUT: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_src = MS_OUT_STR;
        cmd.chunk   = c_r;
        c_nxt       = c_r + 2'd1;
        if (c_r == 2'd3) begin
          cmd.str_wr_out = 1'b1;
          cmd.mac_clr    = 1'b1;
          k_nxt          = k_r - 1'b1;
          if (k_r == DCNT_W'(1)) begin
            state_nxt = ST_DIM;
          end else begin
            state_nxt = ST_STR_IN;
          end
        end
      end
      ST_DIM: begin
        bc_nxt = '0;
        if (stat.str_zero) begin
          cmd.div_zero = 1'b1;
          state_nxt    = (k_r < stat.slice_n) ? ST_TERM : ST_NEXT;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        bc_nxt       = bc_r + 4'd1;
        if (bc_r == DIV_LAST) begin
          cmd.div_done = 1'b1;
          state_nxt    = (k_r < stat.slice_n) ? ST_TERM : ST_NEXT;
        end
      end
      ST_TERM: begin
        cmd.term_en = 1'b1;
        c_nxt       = '0;
        state_nxt   = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_src = MS_BASE;
        cmd.chunk   = c_r;
        c_nxt       = c_r + 2'd1;
        if (c_r == 2'd3) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (k_r == stat.dim_last) begin
          state_nxt = ST_READ;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_DIM;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

/* hdl/ssg_dp.sv */
`default_nettype none
module ssg_dp #(
  parameter int unsigned MAX_DIMS  = ssg_pkg::DEF_MAX_DIMS,
  parameter int unsigned MAX_ELEMS = ssg_pkg::DEF_MAX_ELEMS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ssg_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [ssg_pkg::CFG_W-1:0]        cfg_data,
  input  ssg_pkg::dp_cmd_t                 cmd,
  output ssg_pkg::dp_stat_t                stat,
  input  logic [ssg_pkg::IDX_W-1:0]        elem_index,
  input  logic signed [ssg_pkg::VAL_W-1:0] elem_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [ssg_pkg::VAL_W-1:0] out_value,
  output logic                             out_of_range
);
  import ssg_pkg::*;

  localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned AW = $clog2(MAX_ELEMS);
  localparam int unsigned PW = X_W + FLD_W + 1;
  localparam logic [CFG_W-1:0] ELEMS_LIM = CFG_W'(MAX_ELEMS);
  localparam logic [DCNT_W-1:0] DIMS_MAX = DCNT_W'(MAX_DIMS);
  localparam logic [CFG_W-1:0] ONES_FLD = 64'h0001_0001_0001_0001;

  // configuration registers
  logic [2:0]       dims_used_r, slice_dims_r;
  logic [CFG_W-1:0] in_shape_r, out_shape_r, offset_r, step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_used_r  <= 3'd4;
      slice_dims_r <= 3'd4;
      in_shape_r   <= ONES_FLD;
      out_shape_r  <= ONES_FLD;
      offset_r     <= '0;
      step_r       <= ONES_FLD;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DIMS_USED:  dims_used_r  <= cfg_data[2:0];
        REG_SLICE_DIMS: slice_dims_r <= cfg_data[2:0];
        REG_IN_SHAPE:   in_shape_r   <= cfg_data;
        REG_OUT_SHAPE:  out_shape_r  <= cfg_data;
        REG_OFFSET:     offset_r     <= cfg_data;
        REG_STEP:       step_r       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // per-dimension fields; dimensions past the packed four are neutral
  logic [FLD_W-1:0]        in_shape_a  [MAX_DIMS];
  logic [FLD_W-1:0]        out_shape_a [MAX_DIMS];
  logic signed [FLD_W-1:0] off_a       [MAX_DIMS];
  logic signed [FLD_W-1:0] step_a      [MAX_DIMS];

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_fld
    if (g < NFLD) begin : g_packed
      assign in_shape_a[g]  = in_shape_r[FLD_W*g +: FLD_W];
      assign out_shape_a[g] = out_shape_r[FLD_W*g +: FLD_W];
      assign off_a[g]       = offset_r[FLD_W*g +: FLD_W];
      assign step_a[g]      = step_r[FLD_W*g +: FLD_W];
    end else begin : g_neutral
      assign in_shape_a[g]  = FLD_W'(1);
      assign out_shape_a[g] = FLD_W'(1);
      assign off_a[g]       = '0;
      assign step_a[g]      = FLD_W'(1);
    end
  end

  logic [DCNT_W-1:0] dsat, ssat, sl_ext;

  always_comb begin
    if (dims_used_r == 3'd0) begin
      dsat = DCNT_W'(1);
    end else if ({1'b0, dims_used_r} > DIMS_MAX) begin
      dsat = DIMS_MAX;
    end else begin
      dsat = {1'b0, dims_used_r};
    end
    sl_ext = {1'b0, slice_dims_r};
    ssat   = (sl_ext > dsat) ? dsat : sl_ext;
  end

  logic [DW-1:0] dim_i, dim_m1, str_wa;
  assign dim_i  = cmd.dim[DW-1:0];
  assign dim_m1 = dim_i - 1'b1;
  assign str_wa = cmd.str_init ? dim_i : dim_m1;

  // strides and running products
  logic [CFG_W-1:0] in_str_r  [MAX_DIMS];
  logic [CFG_W-1:0] out_str_r [MAX_DIMS];
  logic [CFG_W-1:0] run_in_r, run_out_r;
  logic [CFG_W-1:0] macc_r, mac_sum;

  // shared 16 x 34 multiply, one 16-bit slice of the wide operand per cycle
  logic [CFG_W-1:0]        a_word;
  logic signed [X_W-1:0]   b_val;
  logic [FLD_W-1:0]        a_chunk;
  logic signed [PW-1:0]    prod;
  logic [CFG_W-1:0]        prod_ext;
  logic signed [X_W-1:0]   x_r;

  always_comb begin
    case (cmd.mac_src)
      MS_IN_STR: begin
        a_word = run_in_r;
        b_val  = {{(X_W-FLD_W){1'b0}}, in_shape_a[dim_i]};
      end
      MS_OUT_STR: begin
        a_word = run_out_r;
        b_val  = {{(X_W-FLD_W){1'b0}}, out_shape_a[dim_i]};
      end
      MS_BASE: begin
        a_word = in_str_r[dim_i];
        b_val  = x_r;
      end
      default: begin
        a_word = '0;
        b_val  = '0;
      end
    endcase
    a_chunk  = a_word[FLD_W*cmd.chunk +: FLD_W];
    prod     = $signed({1'b0, a_chunk}) * b_val;
    prod_ext = {{(CFG_W-PW){prod[PW-1]}}, prod};
    mac_sum  = macc_r + (prod_ext << (FLD_W*cmd.chunk));
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_clr) begin
      macc_r <= '0;
    end else if (cmd.mac_en) begin
      macc_r <= mac_sum;
    end
    if (cmd.str_init) begin
      run_in_r          <= CFG_W'(1);
      run_out_r         <= CFG_W'(1);
      in_str_r[str_wa]  <= CFG_W'(1);
      out_str_r[str_wa] <= CFG_W'(1);
    end
    if (cmd.str_wr_in) begin
      run_in_r         <= mac_sum;
      in_str_r[str_wa] <= mac_sum;
    end
    if (cmd.str_wr_out) begin
      run_out_r         <= mac_sum;
      out_str_r[str_wa] <= mac_sum;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [IDX_W-1:0] tmp_r, rem_r, quo_r, dvd_r, coord_r, q_new;
  logic [IDX_W:0]   r_try, r_new;
  logic [CFG_W-1:0] div_v;
  logic             fits;

  always_comb begin
    div_v = out_str_r[dim_i];
    r_try = {rem_r, dvd_r[IDX_W-1]};
    fits  = {{(CFG_W-IDX_W-1){1'b0}}, r_try} >= div_v;
    r_new = fits ? (r_try - div_v[IDX_W:0]) : r_try;
    q_new = {quo_r[IDX_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tmp_r <= elem_index;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= '0;
      dvd_r <= tmp_r;
    end
    if (cmd.div_step) begin
      rem_r <= r_new[IDX_W-1:0];
      quo_r <= q_new;
      dvd_r <= {dvd_r[IDX_W-2:0], 1'b0};
    end
    if (cmd.div_done) begin
      coord_r <= q_new;
      tmp_r   <= r_new[IDX_W-1:0];
    end
    if (cmd.div_zero) begin
      coord_r <= '0;
    end
  end

  // per-dimension factor: adjusted offset + coord * step
  logic signed [IDX_W+FLD_W:0] cs;
  logic [FLD_W:0]              off_adj;
  logic signed [FLD_W-1:0]     off_raw;

  always_comb begin
    off_raw = off_a[dim_i];
    cs      = $signed({1'b0, coord_r}) * step_a[dim_i];
    off_adj = {off_raw[FLD_W-1], off_raw}
            + (off_raw[FLD_W-1] ? {1'b0, in_shape_a[dim_i]} : {(FLD_W+1){1'b0}});
  end

  always_ff @(posedge clk) begin
    if (cmd.term_en) begin
      x_r <= {{(X_W-IDX_W-FLD_W-1){cs[IDX_W+FLD_W]}}, cs}
           + {{(X_W-FLD_W-1){off_adj[FLD_W]}}, off_adj};
    end
  end

  // element store
  logic [CFG_W-1:0] idx_ext;
  logic             load_ok, in_range;
  logic [VAL_W-1:0] rd_data;

  assign idx_ext  = CFG_W'(elem_index);
  assign load_ok  = idx_ext < ELEMS_LIM;
  assign in_range = macc_r < ELEMS_LIM;

  ssg_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ELEMS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_wr && load_ok),
    .waddr (idx_ext[AW-1:0]),
    .wdata (elem_value),
    .re    (cmd.rd_en && in_range),
    .raddr (macc_r[AW-1:0]),
    .rdata (rd_data)
  );

  // result register
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_value_r <= in_range ? rd_data : '0;
      out_oor_r   <= !in_range;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_of_range = out_oor_r;

  always_comb begin
    stat.dim_last = dsat - 1'b1;
    stat.slice_n  = ssat;
    stat.str_zero = (div_v == '0);
    stat.in_range = in_range;
    stat.out_free = !out_valid_r || out_ready;
  end
endmodule
`default_nettype wire

/* hdl/strided_slice_gather.sv */
`default_nettype none
// channel | dir | fields                              | notes
// in_if   | in  | req_type, elem_index, elem_value    | load (0) or fetch request (1)
// out_if  | out | out_value, out_of_range            | one result per fetch request
// cfg_*   | in  | cfg_we, cfg_addr, cfg_data          | register write, no read-back
//
// A load request is written to the element store when it is accepted. A fetch
// request builds strides, then divides and accumulates for each dimension in use,
// using the shared 16x34 multiplier (four passes per 64-bit product) and the
// one-bit-per-cycle divider. A dimension without offset and step skips the term and
// accumulate, a zero output stride skips the divide; a result still waiting adds stalls.
// rst_n is synchronous; the element store is not cleared.
// A finished result waits in the output register while new requests enter.
module strided_slice_gather #(
  parameter int unsigned MAX_DIMS  = ssg_pkg::DEF_MAX_DIMS,
  parameter int unsigned MAX_ELEMS = ssg_pkg::DEF_MAX_ELEMS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ssg_in_if.sink                     in_if,
  ssg_out_if.source                  out_if,
  input  logic                       cfg_we,
  input  logic [ssg_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [ssg_pkg::CFG_W-1:0]  cfg_data
);
  import ssg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: stride build, per-dimension divide and accumulate, store read
  ssg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_req_type (in_if.req_type),
    .in_ready    (in_if.ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  // registers, strides, multiplier, divider, store and result register
  ssg_dp #(
    .MAX_DIMS  (MAX_DIMS),
    .MAX_ELEMS (MAX_ELEMS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .elem_index   (in_if.elem_index),
    .elem_value   (in_if.elem_value),
    .out_ready    (out_if.ready),
    .out_valid    (out_if.valid),
    .out_value    (out_if.out_value),
    .out_of_range (out_if.out_of_range)
  );
endmodule
`default_nettype wire
